/* design/dtwss_pkg.sv */
// Shared types and constants for the DTW sequence similarity core.
// Used by dtwss_cost, dtwss_sim and dtw_sequence_similarity_core; no dependencies.
package dtwss_pkg;

  localparam int MaxRefLen = 256;
  localparam int IdxW      = $clog2(MaxRefLen);
  localparam int LenW      = IdxW + 1;
  localparam int FeatCount = 5;
  localparam int FeatIdxW  = (FeatCount > 1) ? $clog2(FeatCount) : 1;
  localparam int FeatW     = 16;
  localparam int SqW       = 2 * (FeatW + 1);
  localparam int SumW      = 38;
  localparam int CostW     = SumW / 2;
  localparam int AccW      = 32;
  localparam int SimW      = 16;
  localparam int QCntW     = 9;

  localparam logic [AccW-1:0]  AccMax  = '1;
  localparam logic [QCntW-1:0] QCntMax = '1;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef logic signed [FeatW-1:0] feat_t;
  typedef feat_t [FeatCount-1:0] feat_vec_t;

  typedef struct packed {
    logic        operation;
    logic        absent;
    logic [15:0] feature_a;
    logic [15:0] feature_b;
    logic [15:0] feature_c;
    logic [15:0] feature_d;
    logic [15:0] feature_e;
    logic        last_element;
  } in_t;

  typedef struct packed {
    logic [31:0] warp_distance;
    logic [15:0] similarity;
    logic        error_flag;
    logic        saturated;
  } out_t;

endpackage

/* design/dtw_sequence_similarity_core.sv */
// Top level of the DTW sequence similarity core: reference and DP column
// memories, cell sequencer and result register. Uses dtwss_pkg, dtwss_cost, dtwss_sim.
//
// A reference load is written from the idle state without leaving it. A present
// query element updates one DP cell per stored reference element. Each cell
// passes a read state, a start state, the cost unit (squared differences of
// the five features, then a square root, one root bit per step, and a hand-over
// of the cost) and an update state. The element that ends a query then passes
// through the similarity sequencer and the result register, or goes straight
// to the result register when the result is an error. A result waits in an
// output register while the next transaction is accepted.
// There is no clearing pass: only written memory entries are ever used.
module dtw_sequence_similarity_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dtwss_pkg::in_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dtwss_pkg::out_t  out_data_o
);
  import dtwss_pkg::*;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StRd   = 7'b0000010,
    StLat  = 7'b0000100,
    StCost = 7'b0001000,
    StUpd  = 7'b0010000,
    StRes  = 7'b0100000,
    StSim  = 7'b1000000
  } core_state_e;

  // Output-pending handling is folded into StRes via res_wait_q.
  core_state_e      state_q, state_d;
  feat_vec_t        ref_mem [MaxRefLen];
  logic [AccW-1:0]  prior_mem [MaxRefLen];
  feat_vec_t        ref_rd_q;
  logic [AccW-1:0]  prior_rd_q;

  logic [LenW-1:0]  len_q, len_d;
  logic             closed_q, closed_d, ovf_q, ovf_d, sat_q, sat_d;
  logic [QCntW-1:0] qcnt_q, qcnt_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             first_q, first_d, last_q, last_d;
  logic             res_wait_q, res_wait_d, err_q, err_d;
  logic [AccW-1:0]  diag_q, left_q, dist_q;
  feat_vec_t        qry_q, in_feat;
  logic             out_valid_q, out_valid_d;
  out_t             out_q, out_d;

  logic             acc, rd_en, ref_we, prior_we;
  logic [LenW-1:0]  len_base;
  logic [AccW-1:0]  cell_v, min_v, add_a;
  logic [AccW:0]    add_s;
  logic             cell_sat, cost_start, cost_done, sim_start, sim_done;
  logic [CostW-1:0] cost;
  logic [SimW-1:0]  sim;

  assign in_stall_o = (state_q != StIdle);
  assign acc        = in_valid_i && !in_stall_o;
  assign in_feat    = {in_data_i.feature_e, in_data_i.feature_d, in_data_i.feature_c,
                       in_data_i.feature_b, in_data_i.feature_a};
  assign len_base   = closed_q ? '0 : len_q;

  dtwss_cost u_cost (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cost_start),
    .ref_i   (ref_rd_q),
    .qry_i   (qry_q),
    .done_o  (cost_done),
    .cost_o  (cost)
  );

  dtwss_sim u_sim (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sim_start),
    .dist_i  (dist_q),
    .done_o  (sim_done),
    .sim_o   (sim)
  );

  // DP cell: the first column is a running sum, later ones add the cost to the smallest
  // of the diagonal, left and up neighbors, or for the first row to the previous column's cell.
  always_comb begin
    min_v = (diag_q < prior_rd_q) ? diag_q : prior_rd_q;
    min_v = (min_v < left_q) ? min_v : left_q;
    if (first_q) add_a = left_q;
    else if (idx_q == '0) add_a = prior_rd_q;
    else add_a = min_v;
    add_s    = {1'b0, add_a} + {{(AccW + 1 - CostW){1'b0}}, cost};
    cell_sat = 1'b0;
    if (first_q && idx_q == '0) begin
      cell_v = {{(AccW - CostW){1'b0}}, cost};
    end else if (add_s[AccW]) begin
      cell_v   = AccMax;
      cell_sat = 1'b1;
    end else begin
      cell_v = add_s[AccW-1:0];
    end
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    closed_d    = closed_q;
    ovf_d       = ovf_q;
    sat_d       = sat_q;
    qcnt_d      = qcnt_q;
    idx_d       = idx_q;
    first_d     = first_q;
    last_d      = last_q;
    res_wait_d  = res_wait_q;
    err_d       = err_q;
    rd_en       = 1'b0;
    ref_we      = 1'b0;
    prior_we    = 1'b0;
    cost_start  = 1'b0;
    sim_start   = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      StIdle: begin
        if (acc && in_data_i.operation == OpLoad) begin
          len_d = len_base;
          if (closed_q) begin
            closed_d = 1'b0;
            ovf_d    = 1'b0;
            qcnt_d   = '0;
            sat_d    = 1'b0;
          end
          if (!in_data_i.absent) begin
            if (len_base < LenW'(MaxRefLen)) begin
              ref_we = 1'b1;
              len_d  = len_base + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
          if (in_data_i.last_element) closed_d = 1'b1;
        end else if (acc) begin
          closed_d = 1'b1;
          last_d   = in_data_i.last_element;
          if (!in_data_i.absent && len_q != '0) begin
            first_d = (qcnt_q == '0);
            idx_d   = '0;
            state_d = StRd;
          end else if (in_data_i.last_element) begin
            res_wait_d = 1'b0;
            state_d    = StRes;
          end
        end
      end
      StRd: begin
        rd_en   = 1'b1;
        state_d = StLat;
      end
      StLat: begin
        cost_start = 1'b1;
        state_d    = StCost;
      end
      StCost: begin
        if (cost_done) state_d = StUpd;
      end
      StUpd: begin
        prior_we = 1'b1;
        if (cell_sat) sat_d = 1'b1;
        if (LenW'(idx_q) == len_q - 1'b1) begin
          if (qcnt_q != QCntMax) qcnt_d = qcnt_q + 1'b1;
          res_wait_d = 1'b0;
          state_d    = last_q ? StRes : StIdle;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = StRd;
        end
      end
      StRes: begin
        // First visit decides the error; later visits wait for the output slot.
        if (!res_wait_q) begin
          err_d      = (len_q == '0) || (qcnt_q == '0) || ovf_q;
          res_wait_d = 1'b1;
          if (!((len_q == '0) || (qcnt_q == '0) || ovf_q)) begin
            sim_start = 1'b1;
            state_d   = StSim;
          end
        end else if (!out_valid_q || !out_stall_i) begin
          out_valid_d             = 1'b1;
          out_d.warp_distance     = err_q ? '0 : dist_q;
          out_d.similarity        = err_q ? '0 : sim;
          out_d.error_flag        = err_q;
          out_d.saturated         = err_q ? 1'b0 : sat_q;
          qcnt_d                  = '0;
          sat_d                   = 1'b0;
          state_d                 = StIdle;
        end
      end
      StSim: begin
        if (sim_done) state_d = StRes;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ref_we) ref_mem[len_base[IdxW-1:0]] <= in_feat;
    if (prior_we) prior_mem[idx_q] <= cell_v;
    if (rd_en) begin
      ref_rd_q   <= ref_mem[idx_q];
      prior_rd_q <= prior_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && in_data_i.operation == OpQuery) qry_q <= in_feat;
    if (prior_we) begin
      diag_q <= prior_rd_q;
      left_q <= cell_v;
      if (LenW'(idx_q) == len_q - 1'b1) dist_q <= cell_v;
    end
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= '0;
      closed_q    <= 1'b0;
      ovf_q       <= 1'b0;
      sat_q       <= 1'b0;
      qcnt_q      <= '0;
      idx_q       <= '0;
      first_q     <= 1'b0;
      last_q      <= 1'b0;
      res_wait_q  <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      closed_q    <= closed_d;
      ovf_q       <= ovf_d;
      sat_q       <= sat_d;
      qcnt_q      <= qcnt_d;
      idx_q       <= idx_d;
      first_q     <= first_d;
      last_q      <= last_d;
      res_wait_q  <= res_wait_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LenW'(MaxRefLen))
    else $error("reference length beyond store depth");

  a_upd_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StUpd) |-> (LenW'(idx_q) < len_q))
    else $error("DP cell update beyond reference length");

  a_cost_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cost_done |-> (state_q == StCost))
    else $error("cost result outside the cost wait");

  a_out_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRes && res_wait_q && out_valid_q && out_stall_i) |=>
    (state_q == StRes && $stable(out_q)))
    else $error("pending result overwritten");

endmodule

/* design/dtwss_cost.sv */
// Local cost unit: sum of squared feature differences, one feature per cycle,
// then a floor square root, two radicand bits per cycle. Uses dtwss_pkg.
module dtwss_cost (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  dtwss_pkg::feat_vec_t  ref_i,
  input  dtwss_pkg::feat_vec_t  qry_i,
  output logic                  done_o,
  output logic [dtwss_pkg::CostW-1:0] cost_o
);
  import dtwss_pkg::*;

  localparam int RemW  = CostW + 3;
  localparam int StepW = $clog2(CostW + 1);

  typedef enum logic [2:0] {
    CIdle = 3'b001,
    CSq   = 3'b010,
    CRt   = 3'b100
  } cost_state_e;

  cost_state_e        state_q, state_d;
  feat_vec_t          ref_q, qry_q;
  logic [FeatIdxW-1:0] k_q, k_d;
  logic [StepW-1:0]   s_q, s_d;
  logic [SumW-1:0]    rad_q, rad_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [CostW-1:0]   root_q, root_d;
  logic               done_q, done_d;

  logic signed [FeatW:0]  diff;
  logic signed [SqW-1:0]  sq;
  logic [RemW-1:0]        rem_sh, trial;

  always_comb begin
    diff   = {ref_q[k_q][FeatW-1], ref_q[k_q]} - {qry_q[k_q][FeatW-1], qry_q[k_q]};
    sq     = diff * diff;
    rem_sh = {rem_q[RemW-3:0], rad_q[SumW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
  end

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    s_d     = s_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    done_d  = 1'b0;
    unique case (state_q)
      CIdle: begin
        if (start_i) begin
          state_d = CSq;
          k_d     = '0;
          rad_d   = '0;
        end
      end
      CSq: begin
        rad_d = rad_q + SumW'(unsigned'(sq));
        if (k_q == FeatIdxW'(FeatCount - 1)) begin
          state_d = CRt;
          s_d     = '0;
          rem_d   = '0;
          root_d  = '0;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      CRt: begin
        rad_d = rad_q << 2;
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[CostW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[CostW-2:0], 1'b0};
        end
        if (s_q == StepW'(CostW - 1)) begin
          state_d = CIdle;
          done_d  = 1'b1;
        end else begin
          s_d = s_q + 1'b1;
        end
      end
      default: state_d = CIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CIdle;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == CIdle) begin
      ref_q <= ref_i;
      qry_q <= qry_i;
    end
    k_q    <= k_d;
    s_q    <= s_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign cost_o = root_q;

endmodule

/* design/dtwss_sim.sv */
// Similarity unit: exp(-d*d/2) from a fourth-order series raised to the 256th
// power, through one shared 32x32 multiplier. Uses dtwss_pkg.
module dtwss_sim (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [dtwss_pkg::AccW-1:0] dist_i,
  output logic                       done_o,
  output logic [dtwss_pkg::SimW-1:0] sim_o
);
  import dtwss_pkg::*;

  localparam logic [31:0] Recip6  = 32'd699051;
  localparam logic [31:0] Recip24 = 32'd174763;
  localparam logic [31:0] DistCut = 32'd1280;

  typedef enum logic [10:0] {
    SIdle  = 11'b00000000001,
    SSq    = 11'b00000000010,
    STt    = 11'b00000000100,
    ST2    = 11'b00000001000,
    ST3    = 11'b00000010000,
    ST4    = 11'b00000100000,
    SDiv6  = 11'b00001000000,
    SExp   = 11'b00010000000,
    SPow   = 11'b00100000000,
    SRnd   = 11'b01000000000,
    SDone  = 11'b10000000000
  } sim_state_e;

  sim_state_e   state_q, state_d;
  logic [31:0]  d_q, t_q, t2_q, t3_q, t4_q, q6_q, e_q;
  logic [63:0]  prod_q;
  logic [31:0]  mul_a, mul_b;
  logic         mul_en;
  logic [2:0]   pow_q;
  logic [SimW-1:0] sim_q;
  logic         done_q;
  logic [33:0]  e_sum;
  logic [32:0]  e_rnd;
  logic [16:0]  s_rnd;

  always_comb begin
    e_sum = 34'd1 << 32;
    e_sum = e_sum - {2'b0, t_q} + {3'b0, t2_q[31:1]} - {2'b0, q6_q}
            + {12'b0, prod_q[43:22]};
    e_rnd = 33'((prod_q + 64'h8000_0000) >> 32);
    s_rnd = 17'(({1'b0, e_q} + 33'h8000) >> 16);
  end

  always_comb begin
    state_d = state_q;
    mul_en  = 1'b1;
    mul_a   = e_q;
    mul_b   = e_q;
    unique case (state_q)
      SIdle: begin
        mul_en = 1'b0;
        if (start_i) state_d = SSq;
      end
      SSq: begin
        mul_a = d_q;
        mul_b = d_q;
        state_d = STt;
      end
      STt: begin
        mul_a = {prod_q[24:0], 7'b0};
        mul_b = {prod_q[24:0], 7'b0};
        state_d = ST2;
      end
      ST2: begin
        mul_a = prod_q[63:32];
        mul_b = t_q;
        state_d = ST3;
      end
      ST3: begin
        mul_a = prod_q[63:32];
        mul_b = t_q;
        state_d = ST4;
      end
      ST4: begin
        mul_a = t3_q;
        mul_b = Recip6;
        state_d = SDiv6;
      end
      SDiv6: begin
        mul_a = t4_q;
        mul_b = Recip24;
        state_d = SExp;
      end
      SExp: begin
        mul_en  = 1'b0;
        state_d = SPow;
      end
      SPow: state_d = SRnd;
      SRnd: begin
        mul_en  = 1'b0;
        state_d = (pow_q == 3'd7) ? SDone : SPow;
      end
      SDone: begin
        mul_en  = 1'b0;
        state_d = SIdle;
      end
      default: begin
        mul_en  = 1'b0;
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      done_q  <= 1'b0;
      pow_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == SDone);
      if (state_q == SExp) pow_q <= '0;
      else if (state_q == SRnd) pow_q <= pow_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) prod_q <= mul_a * mul_b;
    if (state_q == SIdle && start_i) d_q <= dist_i;
    if (state_q == STt) t_q <= {prod_q[24:0], 7'b0};
    if (state_q == ST2) t2_q <= prod_q[63:32];
    if (state_q == ST3) t3_q <= prod_q[63:32];
    if (state_q == ST4) t4_q <= prod_q[63:32];
    if (state_q == SDiv6) q6_q <= prod_q[53:22];
    if (state_q == SExp) e_q <= e_sum[33:32] != 2'b00 ? 32'hFFFF_FFFF : e_sum[31:0];
    if (state_q == SRnd) e_q <= e_rnd[31:0];
    if (state_q == SDone) begin
      if (d_q >= DistCut) sim_q <= '0;
      else if (s_rnd[16]) sim_q <= '1;
      else sim_q <= s_rnd[SimW-1:0];
    end
  end

  assign done_o = done_q;
  assign sim_o  = sim_q;

endmodule

/* bench/testbench.sv */
// Self-checking bench for dtw_sequence_similarity_core: feeds reference and query
// transactions, predicts each result with its own DTW model and compares field by field.
// Depends on dtwss_pkg and the core RTL only.
module testbench;
  import dtwss_pkg::*;

  localparam int RefDepth = 256;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  dtw_sequence_similarity_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Predictor state.
  logic signed [15:0] ref_feat [RefDepth][5];
  logic [31:0] dp_col [RefDepth];
  int unsigned ref_len;
  bit ref_closed, ovf_seen, sat_seen;
  int unsigned q_count;

  out_t expected_results [$];
  int errors = 0;
  longint unsigned cycles = 0;
  bit long_hold = 1'b0;
  bit hold_go = 1'b0;
  int burst_left = 0;

  function automatic logic [31:0] cost_of(input logic signed [15:0] q [5], input int r);
    logic [63:0] sum, v, res, b;
    int signed d;
    sum = 0;
    for (int k = 0; k < 5; k++) begin
      d = int'(ref_feat[r][k]) - int'(q[k]);
      if (d < 0) d = -d;
      sum += 64'(d) * 64'(d);
    end
    v = sum; res = 0; b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b; res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] acc_add(input logic [31:0] a, input logic [31:0] c);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, c};
    if (s[32]) begin
      sat_seen = 1'b1;
      return AccMax;
    end
    return s[31:0];
  endfunction

  function automatic logic [15:0] gaussian_of(input logic [31:0] d);
    logic [63:0] t, t2, t3, t4, e;
    if (d >= 32'd1280) return 16'd0;
    t = (64'(d) * 64'(d)) << 7;
    t2 = (t * t) >> 32;
    t3 = (t2 * t) >> 32;
    t4 = (t3 * t) >> 32;
    e = (64'd1 << 32) - t + t2 / 2 - t3 / 6 + t4 / 24;
    if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
    for (int i = 0; i < 8; i++) e = (e * e + (64'd1 << 31)) >> 32;
    e = (e + 64'h8000) >> 16;
    return (e > 64'hFFFF) ? 16'hFFFF : e[15:0];
  endfunction

  task automatic predict_dtw(input in_t it);
    logic signed [15:0] q [5];
    logic [31:0] run, diag, left, up, m, v;
    out_t r;
    q[0] = it.feature_a; q[1] = it.feature_b; q[2] = it.feature_c;
    q[3] = it.feature_d; q[4] = it.feature_e;
    if (it.operation == OpLoad) begin
      if (ref_closed) begin
        ref_len = 0; ref_closed = 0; ovf_seen = 0; q_count = 0; sat_seen = 0;
      end
      if (!it.absent) begin
        if (ref_len < RefDepth) begin
          for (int k = 0; k < 5; k++) ref_feat[ref_len][k] = q[k];
          ref_len++;
        end else ovf_seen = 1'b1;
      end
      if (it.last_element) ref_closed = 1'b1;
      return;
    end
    ref_closed = 1'b1;
    if (!it.absent && ref_len > 0) begin
      if (q_count == 0) begin
        run = 0;
        for (int i = 0; i < ref_len; i++) begin
          run = (i == 0) ? cost_of(q, 0) : acc_add(run, cost_of(q, i));
          dp_col[i] = run;
        end
      end else begin
        diag = dp_col[0];
        left = acc_add(dp_col[0], cost_of(q, 0));
        dp_col[0] = left;
        for (int i = 1; i < ref_len; i++) begin
          up = dp_col[i];
          m = (diag < up) ? diag : up;
          if (left < m) m = left;
          v = acc_add(m, cost_of(q, i));
          dp_col[i] = v;
          diag = up;
          left = v;
        end
      end
      if (q_count < 511) q_count++;
    end
    if (!it.last_element) return;
    if (ref_len == 0 || q_count == 0 || ovf_seen) begin
      r = '0; r.error_flag = 1'b1;
    end else begin
      r.warp_distance = dp_col[ref_len - 1];
      r.similarity = gaussian_of(r.warp_distance);
      r.error_flag = 1'b0;
      r.saturated = sat_seen;
    end
    expected_results.insert(expected_results.size(), r);
    q_count = 0;
    sat_seen = 0;
  endtask

  // Sends one transaction in bursts with random gaps.
  task automatic send_item(input in_t it);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_dtw(it);
    burst_left--;
  endtask

  task automatic wait_drained;
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic in_t make_item(input bit op, input bit gone, input bit fin,
                                    input int span);
    in_t it;
    it.operation = op;
    it.absent = gone;
    it.last_element = fin;
    it.feature_a = 16'($urandom_range(0, 2 * span) - span);
    it.feature_b = 16'($urandom_range(0, 2 * span) - span);
    it.feature_c = 16'($urandom_range(0, 2 * span) - span);
    it.feature_d = 16'($urandom_range(0, 2 * span) - span);
    it.feature_e = 16'($urandom_range(0, 2 * span) - span);
    return it;
  endfunction

  function automatic in_t fixed_item(input bit op, input bit fin, input logic [15:0] f);
    in_t it;
    it = '0;
    it.operation = op;
    it.last_element = fin;
    it.feature_a = f; it.feature_b = f; it.feature_c = f; it.feature_d = f;
    it.feature_e = f;
    return it;
  endfunction

  task automatic test_extremes;
    send_item(fixed_item(OpLoad, 0, 16'h8000));
    send_item(fixed_item(OpLoad, 1, 16'h7FFF));
    send_item(fixed_item(OpQuery, 0, 16'h7FFF));
    send_item(fixed_item(OpQuery, 1, 16'h8000));
    // Identical vectors give zero distance and full similarity.
    send_item(fixed_item(OpLoad, 1, 16'h0100));
    send_item(fixed_item(OpQuery, 1, 16'h0100));
    send_item(fixed_item(OpQuery, 1, 16'h0180));
    wait_drained();
  endtask

  task automatic test_error_cases;
    in_t it;
    // Query ends with only absent elements, then a load after close.
    it = make_item(OpQuery, 1, 1, 100); send_item(it);
    it = make_item(OpLoad, 1, 1, 100); send_item(it);
    it = make_item(OpQuery, 0, 1, 100); send_item(it);  // empty reference
    it = make_item(OpLoad, 0, 0, 300); send_item(it);
    it = make_item(OpLoad, 1, 0, 300); send_item(it);
    it = make_item(OpQuery, 0, 0, 300); send_item(it);  // closes the reference
    it = make_item(OpQuery, 1, 0, 300); send_item(it);
    it = make_item(OpQuery, 0, 1, 300); send_item(it);
    wait_drained();
  endtask

  task automatic test_overflow;
    in_t it;
    for (int i = 0; i < RefDepth + 2; i++) begin
      it = make_item(OpLoad, 0, i == RefDepth + 1, 32768);
      it.absent = 1'b0;
      send_item(it);
    end
    it = make_item(OpQuery, 0, 1, 32768); send_item(it);
    wait_drained();
  endtask

  // The receiver holds off while several short queries complete, so results
  // back up and the input stalls.
  task automatic test_backpressure;
    in_t it;
    hold_go = 1'b1;
    for (int i = 0; i < 2; i++) begin
      it = make_item(OpLoad, 0, i == 1, 500); send_item(it);
    end
    for (int j = 0; j < 6; j++) begin
      it = make_item(OpQuery, 0, 1, 500); send_item(it);
    end
    wait_drained();
  endtask

  task automatic test_random;
    in_t it;
    int n, len, span;
    n = 0;
    while (n < 220) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
      span = ($urandom_range(0, 3) == 0) ? 32768 : $urandom_range(1, 1200);
      for (int i = 0; i < len; i++) begin
        it = make_item(OpLoad, $urandom_range(0, 15) == 0, i == len - 1, span);
        send_item(it); n++;
      end
      repeat ($urandom_range(1, 3)) begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          it = make_item(OpQuery, $urandom_range(0, 15) == 0, i == len - 1, span);
          send_item(it); n++;
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        it = make_item($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                       32768);
        send_item(it); n++;
      end
    end
    wait_drained();
  endtask

  // Receiver stall pattern, with one long hold-off.
  always @(posedge clk_i) begin
    if (long_hold) out_stall_i <= 1'b1;
    else if (cycles % 2000 < 700) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(0, 2) == 0);
  end

  initial begin
    wait (hold_go);
    long_hold <= 1'b1;
    repeat (600) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // Result checker.
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (out_data_o.warp_distance !== e.warp_distance) begin
          $display("%0t: warp_distance expected %0d actual %0d", $time, e.warp_distance,
                   out_data_o.warp_distance);
          errors++;
        end
        if (out_data_o.similarity !== e.similarity) begin
          $display("%0t: similarity expected %0d actual %0d", $time, e.similarity,
                   out_data_o.similarity);
          errors++;
        end
        if (out_data_o.error_flag !== e.error_flag) begin
          $display("%0t: error_flag expected %0b actual %0b", $time, e.error_flag,
                   out_data_o.error_flag);
          errors++;
        end
        if (out_data_o.saturated !== e.saturated) begin
          $display("%0t: saturated expected %0b actual %0b", $time, e.saturated,
                   out_data_o.saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == 64'd6_000_000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    ref_len = 0; ref_closed = 0; ovf_seen = 0; q_count = 0; sat_seen = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_error_cases();
    test_overflow();
    test_backpressure();
    test_random();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
